// ===== rtl/core/pwp_pkg.sv =====
// Package: shared types, constants and commands for the path window pruner.
`default_nettype none
package pwp_pkg;
   localparam int DEF_PLAN_DEPTH = 1024;
   localparam int COORD_W = 24;
   localparam int SQ_W = 50;
   localparam int DIST_W = 25;
   localparam int SUM_W = 32;
   localparam int PRUNE_W = 24;
   localparam int INDEX_W = 10;
   localparam int COUNT_W = 11;
   localparam logic [PRUNE_W-1:0] PRUNE_RESET = 24'd3072;
   localparam logic [1:0] CSR_PRUNE_ADDR = 2'd0;
   localparam logic REQ_LOAD = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE, ST_LOAD, ST_SCAN_RD, ST_SCAN_CMP, ST_NEAR_SQRT, ST_WALK_RD,
      ST_WALK_SQRT, ST_WALK_ACC, ST_DONE
   } state_type;

   typedef struct packed {
      logic load_store;    // write or drop the held load beat
      logic query_init;    // latch robot position, clear search regs
      logic scan_read;     // read entry at scan index
      logic scan_cmp;      // compare held entry with best
      logic near_start;    // start sqrt of best distance
      logic walk_init;     // set walk index to best+1
      logic walk_read;     // read walk entry
      logic seg_start;     // start sqrt of segment
      logic walk_acc;      // add segment, test limit
      logic rsp_load;      // fill result register
   } cmd_type;

   typedef struct packed {
      logic is_query;
      logic plan_empty;
      logic scan_last;     // scan index at last stored point
      logic walk_end;      // walk index past last stored point
      logic sqrt_busy;
      logic over_limit;    // sum just exceeded the limit
   } stat_type;
endpackage
`default_nettype wire

// ===== rtl/core/pwp_if.sv =====
// Interfaces: request and response channels with valid/ready handshake.
`default_nettype none
interface pwp_req_if;
   logic req_valid;
   logic req_ready;
   logic req_type;
   logic signed [23:0] pos_x;
   logic signed [23:0] pos_y;
   logic new_plan;
   modport source (output req_valid, req_type, pos_x, pos_y, new_plan, input req_ready);
   modport sink (input req_valid, req_type, pos_x, pos_y, new_plan, output req_ready);
endinterface

interface pwp_rsp_if;
   logic rsp_valid;
   logic rsp_ready;
   logic [9:0] start_index;
   logic [10:0] window_count;
   logic [24:0] nearest_distance;
   logic plan_empty;
   logic plan_overflow;
   modport source (output rsp_valid, start_index, window_count, nearest_distance,
      plan_empty, plan_overflow, input rsp_ready);
   modport sink (input rsp_valid, start_index, window_count, nearest_distance,
      plan_empty, plan_overflow, output rsp_ready);
endinterface
`default_nettype wire

// ===== rtl/core/path_window_pruner.sv =====
// Path window pruner: stores a planar plan and answers nearest-point window queries.
// Load beat: taken in idle, then one load state back to idle. Query beat: a decode state, a read
// and a compare per stored point in the scan, the nearest sqrt, then a read, a sqrt and an
// accumulate per walked segment, a read to close the walk, then a state to fill the result.
// One item at a time: req_ready stays low until the result beat is taken.
// Sync active-high reset empties the plan, clears overflow, prune limit back to 3072.
`default_nettype none
module path_window_pruner
   import pwp_pkg::*;
#(
   parameter int PLAN_DEPTH = DEF_PLAN_DEPTH
)(
   input  wire logic        clock,
   input  wire logic        reset,
   pwp_req_if.sink          req,
   pwp_rsp_if.source        rsp,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [1:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   cmd_type cmd;
   stat_type stat;
   logic [PRUNE_W-1:0] prune_ff;

   // config register, written on the APB access phase
   assign csr_pready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) prune_ff <= PRUNE_RESET;
      else if (csr_psel && csr_penable && csr_pwrite && csr_paddr == CSR_PRUNE_ADDR)
         prune_ff <= csr_pwdata[PRUNE_W-1:0];
   end
   assign csr_prdata = (csr_paddr == CSR_PRUNE_ADDR) ? {8'd0, prune_ff} : 32'd0;

   pwp_ctrl u_ctrl (.clock, .reset, .req_valid(req.req_valid), .req_ready(req.req_ready),
      .rsp_valid(rsp.rsp_valid), .rsp_ready(rsp.rsp_ready), .stat, .cmd);

   pwp_dpath #(.PLAN_DEPTH(PLAN_DEPTH)) u_dpath (.clock, .reset,
      .in_type(req.req_type), .in_x(req.pos_x), .in_y(req.pos_y), .in_new(req.new_plan),
      .prune(prune_ff), .cmd, .stat, .o_index(rsp.start_index),
      .o_count(rsp.window_count), .o_dist(rsp.nearest_distance),
      .o_empty(rsp.plan_empty), .o_over(rsp.plan_overflow));
endmodule
`default_nettype wire

// ===== rtl/core/pwp_sqrt.sv =====
// Iterative floor square root, one result bit per cycle.
`default_nettype none
module pwp_sqrt
   import pwp_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [SQ_W-1:0]   value,
   output logic                   busy,
   output logic [DIST_W-1:0]      root
);
   localparam int STEPS = SQ_W / 2;
   logic [SQ_W-1:0] rem_ff, rem_in;
   logic [DIST_W-1:0] root_ff, root_in;
   logic [SQ_W-1:0] src_ff, src_in;
   logic [$clog2(STEPS+1)-1:0] cnt_ff, cnt_in;
   logic [SQ_W+1:0] trial;
   logic [SQ_W+1:0] rem_sh;

   always_comb begin
      rem_sh = {rem_ff, src_ff[SQ_W-1 -: 2]};
      trial = {{(SQ_W-DIST_W){1'b0}}, root_ff, 2'b01};
      rem_in = rem_ff;
      root_in = root_ff;
      src_in = src_ff;
      cnt_in = cnt_ff;
      if (start) begin
         rem_in = '0;
         root_in = '0;
         src_in = value;
         cnt_in = ($clog2(STEPS+1))'(STEPS);
      end else if (cnt_ff != '0) begin
         src_in = {src_ff[SQ_W-3:0], 2'b00};
         cnt_in = cnt_ff - 1'b1;
         if (rem_sh >= trial) begin
            rem_in = SQ_W'(rem_sh - trial);
            root_in = {root_ff[DIST_W-2:0], 1'b1};
         end else begin
            rem_in = SQ_W'(rem_sh);
            root_in = {root_ff[DIST_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      root_ff <= root_in;
      src_ff <= src_in;
      if (reset) cnt_ff <= '0;
      else cnt_ff <= cnt_in;
   end

   assign busy = (cnt_ff != '0);
   assign root = root_ff;
endmodule
`default_nettype wire

// ===== rtl/core/pwp_ctrl.sv =====
// Controller: sequences load, nearest scan and window walk.
`default_nettype none
module pwp_ctrl
   import pwp_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  wire logic     rsp_ready,
   input  wire stat_type stat,
   output cmd_type       cmd
);
   state_type state_ff, state_in;
   logic rv_ff, rv_in;
   logic take;
   logic near_go_ff, seg_go_ff;

   assign req_ready = (state_ff == ST_IDLE) && !rv_ff;
   assign take = req_valid && req_ready;
   assign rsp_valid = rv_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (take) state_in = ST_LOAD;
         ST_LOAD: begin
            if (!stat.is_query) state_in = ST_IDLE;
            else if (stat.plan_empty) state_in = ST_DONE;
            else state_in = ST_SCAN_RD;
         end
         ST_SCAN_RD: state_in = ST_SCAN_CMP;
         ST_SCAN_CMP: state_in = stat.scan_last ? ST_NEAR_SQRT : ST_SCAN_RD;
         ST_NEAR_SQRT: if (near_go_ff && !stat.sqrt_busy) state_in = ST_WALK_RD;
         ST_WALK_RD: state_in = stat.walk_end ? ST_DONE : ST_WALK_SQRT;
         ST_WALK_SQRT: if (seg_go_ff && !stat.sqrt_busy) state_in = ST_WALK_ACC;
         ST_WALK_ACC: state_in = stat.over_limit ? ST_DONE : ST_WALK_RD;
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      case (state_ff)
         ST_IDLE: begin
            cmd.load_store = take;
            cmd.query_init = take;
         end
         ST_SCAN_RD: cmd.scan_read = 1'b1;
         ST_SCAN_CMP: cmd.scan_cmp = 1'b1;
         ST_NEAR_SQRT: begin
            cmd.near_start = !near_go_ff;
            cmd.walk_init = !stat.sqrt_busy && near_go_ff;
         end
         ST_WALK_RD: cmd.walk_read = 1'b1;
         ST_WALK_SQRT: cmd.seg_start = !seg_go_ff;
         ST_WALK_ACC: cmd.walk_acc = 1'b1;
         ST_DONE: cmd.rsp_load = 1'b1;
         default: cmd = '0;
      endcase
   end

   always_comb begin
      rv_in = rv_ff;
      if (state_ff == ST_DONE) rv_in = 1'b1;
      else if (rsp_ready) rv_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rv_ff <= 1'b0;
         near_go_ff <= 1'b0;
         seg_go_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rv_ff <= rv_in;
         near_go_ff <= (state_ff == ST_NEAR_SQRT) && (state_in == ST_NEAR_SQRT);
         seg_go_ff <= (state_ff == ST_WALK_SQRT) && (state_in == ST_WALK_SQRT);
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("rsp dropped");
   a_no_take_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> !req_ready) else $error("ready while busy");
   a_done_once: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DONE |=> rv_ff) else $error("done lost");
endmodule
`default_nettype wire

// ===== rtl/core/pwp_dpath.sv =====
// Datapath: point store, distance math, search and walk registers.
`default_nettype none
module pwp_dpath
   import pwp_pkg::*;
#(
   parameter int PLAN_DEPTH = DEF_PLAN_DEPTH
)(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    in_type,
   input  wire logic signed [COORD_W-1:0] in_x,
   input  wire logic signed [COORD_W-1:0] in_y,
   input  wire logic                    in_new,
   input  wire logic [PRUNE_W-1:0]      prune,
   input  wire cmd_type                 cmd,
   output stat_type                     stat,
   output logic [INDEX_W-1:0]           o_index,
   output logic [COUNT_W-1:0]           o_count,
   output logic [DIST_W-1:0]            o_dist,
   output logic                         o_empty,
   output logic                         o_over
);
   localparam int AW = $clog2(PLAN_DEPTH);
   localparam int CW = $clog2(PLAN_DEPTH + 1);

   logic signed [COORD_W-1:0] mem_x [PLAN_DEPTH];
   logic signed [COORD_W-1:0] mem_y [PLAN_DEPTH];
   logic signed [COORD_W-1:0] rd_x_ff, rd_y_ff, prev_x_ff, prev_y_ff;
   logic signed [COORD_W-1:0] rx_ff, ry_ff, ax, ay;
   logic type_ff, over_ff, over_in;
   logic [CW-1:0] count_ff, count_in, idx_ff, idx_in, best_ff, wcnt_ff;
   logic [SQ_W-1:0] best_sq_ff, sq;
   logic [SUM_W-1:0] sum_ff;
   logic [SUM_W:0] sum_wide;
   logic [DIST_W-1:0] near_ff;
   logic signed [COORD_W:0] dx, dy;
   logic [2*COORD_W+1:0] dx2, dy2;
   logic sq_start, sq_busy;
   logic [DIST_W-1:0] root;
   logic [SQ_W-1:0] sq_arg;

   // write address is the load slot, read address is the search index
   always_ff @(posedge clock) begin
      if (cmd.load_store && !in_type && (in_new || count_ff < CW'(PLAN_DEPTH))) begin
         mem_x[in_new ? AW'(0) : count_ff[AW-1:0]] <= in_x;
         mem_y[in_new ? AW'(0) : count_ff[AW-1:0]] <= in_y;
      end
      if (cmd.scan_read || cmd.walk_read) begin
         rd_x_ff <= mem_x[idx_ff[AW-1:0]];
         rd_y_ff <= mem_y[idx_ff[AW-1:0]];
      end
   end

   always_comb begin
      count_in = count_ff;
      over_in = over_ff;
      if (cmd.load_store && !in_type) begin
         if (in_new) begin
            count_in = CW'(1);
            over_in = 1'b0;
         end else if (count_ff < CW'(PLAN_DEPTH)) count_in = count_ff + 1'b1;
         else over_in = 1'b1;
      end
   end

   // distance: walk uses previous point, scan uses robot
   assign ax = cmd.seg_start ? prev_x_ff : rx_ff;
   assign ay = cmd.seg_start ? prev_y_ff : ry_ff;
   assign dx = (COORD_W+1)'(rd_x_ff) - (COORD_W+1)'(ax);
   assign dy = (COORD_W+1)'(rd_y_ff) - (COORD_W+1)'(ay);
   assign dx2 = (2*COORD_W+2)'(dx * dx);
   assign dy2 = (2*COORD_W+2)'(dy * dy);
   assign sq = SQ_W'(dx2) + SQ_W'(dy2);

   assign sq_start = cmd.near_start || cmd.seg_start;
   assign sq_arg = cmd.near_start ? best_sq_ff : sq;
   pwp_sqrt u_sqrt (.clock, .reset, .start(sq_start), .value(sq_arg),
      .busy(sq_busy), .root);

   assign sum_wide = {1'b0, sum_ff} + (SUM_W+1)'(root);

   always_comb begin
      idx_in = idx_ff;
      if (cmd.query_init) idx_in = '0;
      else if (cmd.scan_cmp && !stat.scan_last) idx_in = idx_ff + 1'b1;
      else if (cmd.walk_init) idx_in = best_ff + 1'b1;
      else if (cmd.walk_acc) idx_in = idx_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         over_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         over_ff <= over_in;
      end
      idx_ff <= idx_in;
      if (cmd.query_init) begin
         type_ff <= in_type;
         rx_ff <= in_x;
         ry_ff <= in_y;
         best_ff <= '0;
         sum_ff <= '0;
         wcnt_ff <= CW'(1);
      end
      if (cmd.scan_cmp && (idx_ff == '0 || sq < best_sq_ff)) begin
         best_sq_ff <= sq;
         best_ff <= idx_ff;
      end
      if (cmd.scan_cmp && (idx_ff == '0 || sq < best_sq_ff)) begin
         prev_x_ff <= rd_x_ff;
         prev_y_ff <= rd_y_ff;
      end
      if (cmd.walk_init) near_ff <= root;
      if (cmd.walk_acc) begin
         sum_ff <= sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
         prev_x_ff <= rd_x_ff;
         prev_y_ff <= rd_y_ff;
         if (!stat.over_limit) wcnt_ff <= wcnt_ff + 1'b1;
      end
   end

   always_comb begin
      stat.is_query = type_ff;
      stat.plan_empty = (count_ff == '0);
      stat.scan_last = (idx_ff + 1'b1 >= count_ff);
      stat.walk_end = (idx_ff >= count_ff);
      stat.sqrt_busy = sq_busy;
      stat.over_limit = sum_wide[SUM_W] || sum_wide[SUM_W-1:0] > SUM_W'(prune);
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         o_empty <= (count_ff == '0);
         o_over <= over_ff;
         o_index <= (count_ff == '0) ? '0 : INDEX_W'(best_ff);
         o_count <= (count_ff == '0) ? '0 : COUNT_W'(wcnt_ff);
         o_dist <= (count_ff == '0) ? '0 : near_ff;
      end
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(PLAN_DEPTH)) else $error("count overflow");
   a_best_range: assert property (@(posedge clock) disable iff (reset)
      cmd.walk_init |-> best_ff < count_ff) else $error("best out of range");
   a_wcnt: assert property (@(posedge clock) disable iff (reset)
      cmd.walk_acc && !stat.over_limit |=> wcnt_ff == $past(wcnt_ff) + 1'b1)
      else $error("window count slip");
endmodule
`default_nettype wire

// ===== bench/tb_path_window_pruner.sv =====
// Testbench for path_window_pruner: plan loads and window queries checked against a local model.
`timescale 1ns / 100ps
`default_nettype none
module tb_path_window_pruner;
   import pwp_pkg::*;

   localparam int DEPTH = DEF_PLAN_DEPTH;
   localparam int WATCHDOG_LIMIT = 200000;
   localparam int SETTLE_CYCLES = 40;

   // one input beat
   typedef struct {
      logic                      kind;
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic                      fresh;
   } point_beat_type;

   // one result beat
   typedef struct {
      logic [INDEX_W-1:0] start_index;
      logic [COUNT_W-1:0] window_count;
      logic [DIST_W-1:0]  nearest_distance;
      logic               plan_empty;
      logic               plan_overflow;
   } window_answer_type;

   logic clock;
   logic reset;
   logic csr_psel, csr_penable, csr_pwrite;
   logic [1:0] csr_paddr;
   logic [31:0] csr_pwdata, csr_prdata;
   logic csr_pready;

   pwp_req_if req_bus ();
   pwp_rsp_if rsp_bus ();

   path_window_pruner u_dut (
      .clock(clock), .reset(reset), .req(req_bus.sink), .rsp(rsp_bus.source),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      clock = 1'b1; #4;
      clock = 1'b0; #4;
   end

   // ---------------------------------------------------------------- model state
   logic signed [COORD_W-1:0] plan_x [DEPTH];
   logic signed [COORD_W-1:0] plan_y [DEPTH];
   int unsigned plan_len;
   logic plan_dropped;
   logic [PRUNE_W-1:0] prune_limit;

   point_beat_type    pending_points[$];
   window_answer_type pending_answers[$];
   int mismatches;
   int idle_cycles;
   bit no_idle;       // phases with back-to-back beats on both sides
   bit beat_taken;    // request beat accepted at the last rising edge
   int req_gap, rsp_gap;

   function automatic longint unsigned floor_root(longint unsigned v);
      longint unsigned root, trial;
      root = 0;
      for (int b = 31; b >= 0; b--) begin
         trial = root | (64'd1 << b);
         if (trial * trial <= v) root = trial;
      end
      return root;
   endfunction

   function automatic longint unsigned sq_span(logic signed [COORD_W-1:0] ax,
         logic signed [COORD_W-1:0] ay, logic signed [COORD_W-1:0] bx,
         logic signed [COORD_W-1:0] by);
      longint dx, dy;
      dx = longint'(ax) - longint'(bx);
      dy = longint'(ay) - longint'(by);
      return longint'(dx * dx) + longint'(dy * dy);
   endfunction

   // Apply one accepted beat to the plan; queries queue their answer.
   function automatic void plan_apply(point_beat_type b);
      window_answer_type a;
      longint unsigned best_sq, d, acc;
      int unsigned best, cnt;
      if (b.kind == REQ_LOAD) begin
         if (b.fresh) begin
            plan_len = 0;
            plan_dropped = 1'b0;
         end
         if (plan_len < DEPTH) begin
            plan_x[plan_len] = b.x;
            plan_y[plan_len] = b.y;
            plan_len++;
         end else plan_dropped = 1'b1;
         return;
      end
      a.plan_overflow = plan_dropped;
      if (plan_len == 0) begin
         a.start_index = '0;
         a.window_count = '0;
         a.nearest_distance = '0;
         a.plan_empty = 1'b1;
         pending_answers.insert(pending_answers.size(), a);
         return;
      end
      best = 0;
      best_sq = sq_span(b.x, b.y, plan_x[0], plan_y[0]);
      for (int unsigned i = 1; i < plan_len; i++) begin
         d = sq_span(b.x, b.y, plan_x[i], plan_y[i]);
         if (d < best_sq) begin
            best_sq = d;
            best = i;
         end
      end
      // walk forward; running length saturates at 32 bits
      cnt = 1;
      acc = 0;
      for (int unsigned i = best + 1; i < plan_len; i++) begin
         acc += floor_root(sq_span(plan_x[i], plan_y[i], plan_x[i-1], plan_y[i-1]));
         if (acc > 64'hFFFF_FFFF) acc = 64'hFFFF_FFFF;
         if (acc > prune_limit) break;
         cnt++;
      end
      a.start_index = best[INDEX_W-1:0];
      a.window_count = cnt[COUNT_W-1:0];
      a.nearest_distance = DIST_W'(floor_root(best_sq));
      a.plan_empty = 1'b0;
      pending_answers.insert(pending_answers.size(), a);
   endfunction

   function automatic int pick_gap();
      int r;
      if (no_idle) return 0;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // ---------------------------------------------------------------- driver
   always @(posedge clock) begin
      if (!reset && req_bus.req_valid && req_bus.req_ready) begin
         plan_apply('{req_bus.req_type, req_bus.pos_x, req_bus.pos_y, req_bus.new_plan});
         beat_taken = 1'b1;
      end
   end

   always @(negedge clock) begin
      point_beat_type nb;
      if (reset) begin
         req_bus.req_valid <= 1'b0;
         beat_taken = 1'b0;
      end else if (req_bus.req_valid && !beat_taken) begin
         // hold the beat until it is taken
      end else begin
         beat_taken = 1'b0;
         if (req_gap > 0) begin
            req_gap--;
            req_bus.req_valid <= 1'b0;
         end else if (pending_points.size() > 0) begin
            nb = pending_points.pop_front();
            req_bus.req_type <= nb.kind;
            req_bus.pos_x <= nb.x;
            req_bus.pos_y <= nb.y;
            req_bus.new_plan <= nb.fresh;
            req_bus.req_valid <= 1'b1;
            req_gap = pick_gap();
         end else req_bus.req_valid <= 1'b0;
      end
   end

   // ---------------------------------------------------------------- result side
   always @(negedge clock) begin
      if (reset) rsp_bus.rsp_ready <= 1'b0;
      else if (rsp_gap > 0) begin
         rsp_gap--;
         rsp_bus.rsp_ready <= 1'b0;
      end else begin
         rsp_bus.rsp_ready <= 1'b1;
         rsp_gap = pick_gap();
      end
   end

   always @(posedge clock) begin
      window_answer_type e;
      if (!reset && rsp_bus.rsp_valid && rsp_bus.rsp_ready) begin
         if (pending_answers.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result beat at %0t", $time);
         end else begin
            e = pending_answers.pop_front();
            if (rsp_bus.start_index !== e.start_index ||
                rsp_bus.window_count !== e.window_count ||
                rsp_bus.nearest_distance !== e.nearest_distance ||
                rsp_bus.plan_empty !== e.plan_empty ||
                rsp_bus.plan_overflow !== e.plan_overflow) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("mismatch at %0t: exp idx=%0d cnt=%0d dist=%0d empty=%0b ovf=%0b",
                     $time, e.start_index, e.window_count, e.nearest_distance,
                     e.plan_empty, e.plan_overflow);
                  $display("   got idx=%0d cnt=%0d dist=%0d empty=%0b ovf=%0b",
                     rsp_bus.start_index, rsp_bus.window_count,
                     rsp_bus.nearest_distance, rsp_bus.plan_empty,
                     rsp_bus.plan_overflow);
               end
            end
         end
      end
   end

   // watchdog: cycles without any accepted beat
   always @(posedge clock) begin
      if (reset || (req_bus.req_valid && req_bus.req_ready) ||
          (rsp_bus.rsp_valid && rsp_bus.rsp_ready)) idle_cycles <= 0;
      else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else idle_cycles <= idle_cycles + 1;
   end

   // ---------------------------------------------------------------- stimulus
   function automatic void add_load(int x, int y, bit fresh);
      pending_points.insert(pending_points.size(),
         point_beat_type'{REQ_LOAD, x[COORD_W-1:0], y[COORD_W-1:0], fresh});
   endfunction

   function automatic void add_query(int x, int y);
      pending_points.insert(pending_points.size(),
         point_beat_type'{REQ_QUERY, x[COORD_W-1:0], y[COORD_W-1:0],
                          1'($urandom_range(0, 1))});
   endfunction

   function automatic int any_coord();
      return $signed($urandom_range(0, 24'hFFFFFF) << 8) >>> 8;
   endfunction

   // wait until the block has drained, then past the last load
   task automatic settle();
      while (pending_points.size() > 0 || req_bus.req_valid || pending_answers.size() > 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // register write in setup and access phases, issued on falling edges, then read back
   task automatic write_prune(logic [PRUNE_W-1:0] value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_PRUNE_ADDR;
      csr_pwdata <= 32'(value);
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      prune_limit = value;
      if (!csr_pready || csr_prdata !== 32'(value)) begin
         mismatches++;
         if (mismatches <= 10)
            $display("register readback at %0t: exp %0d got %0d", $time, value, csr_prdata);
      end
   endtask

   initial begin
      int issued, bx, by, n;
      int unsigned lim;
      reset = 1'b1;
      csr_psel = 1'b0; csr_penable = 1'b0; csr_pwrite = 1'b0;
      csr_paddr = '0; csr_pwdata = '0;
      req_bus.req_valid = 1'b0; req_bus.req_type = REQ_LOAD;
      req_bus.pos_x = '0; req_bus.pos_y = '0; req_bus.new_plan = 1'b0;
      rsp_bus.rsp_ready = 1'b0;
      plan_len = 0; plan_dropped = 1'b0; prune_limit = PRUNE_RESET;
      mismatches = 0; idle_cycles = 0; req_gap = 0; rsp_gap = 0; no_idle = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: empty plan, corner coordinates, nearest tie, new plan
      add_query(0, 0);
      add_load(-8388608, -8388608, 1'b0);
      add_load(8388607, 8388607, 1'b0);
      add_load(8388607, -8388608, 1'b0);
      add_query(8388607, 8388607);
      add_query(-8388608, 8388607);
      add_load(100, 0, 1'b1);
      add_load(-100, 0, 1'b0);     // equidistant with the first point from origin
      add_load(-100, 1000, 1'b0);
      add_load(-100, 3000, 1'b0);
      add_query(0, 0);
      add_query(-100, 999);
      add_load(0, 0, 1'b1);
      add_query(1, -1);
      settle();
      write_prune('0);             // window collapses to one point unless segments are zero
      add_load(0, 0, 1'b1);
      add_load(0, 0, 1'b0);
      add_load(5, 0, 1'b0);
      add_query(0, 0);
      settle();

      // long walk at the widest limit
      write_prune(24'hFFFFFF);
      add_load(0, 0, 1'b1);
      for (int i = 1; i < 40; i++)
         add_load(i * 4000 - 2000000, ((i * 7919) % 5000) - 2500, 1'b0);
      add_query(-2000000, 0);
      add_query(8388607, -8388608);
      settle();
      write_prune(24'd20000);
      add_query(100000, 100);
      add_load(7, 7, 1'b1);
      add_query(0, 0);
      settle();
      write_prune(PRUNE_RESET);

      // random: mostly fresh short plans with queries, some noise
      issued = 0;
      while (issued < 220) begin
         no_idle = ($urandom_range(0, 5) == 0);
         if ($urandom_range(0, 9) < 7) begin
            n = $urandom_range(1, 20);
            bx = any_coord() / 2;
            by = any_coord() / 2;
            for (int i = 0; i < n; i++) begin
               if ($urandom_range(0, 7) == 0) add_load(any_coord(), any_coord(), i == 0);
               else add_load(bx + $urandom_range(0, 4000) - 2000,
                             by + $urandom_range(0, 4000) - 2000, i == 0);
               bx += $urandom_range(0, 3000) - 1000;
               by += $urandom_range(0, 3000) - 1000;
            end
            issued += n;
            for (int q = $urandom_range(1, 4); q > 0; q--) begin
               if ($urandom_range(0, 3) == 0) add_query(any_coord(), any_coord());
               else add_query(bx + $urandom_range(0, 20000) - 10000,
                              by + $urandom_range(0, 20000) - 10000);
               issued++;
            end
         end else begin
            for (int k = $urandom_range(1, 6); k > 0; k--) begin
               if ($urandom_range(0, 1)) add_query(any_coord(), any_coord());
               else add_load(any_coord(), any_coord(), 1'($urandom_range(0, 3) == 0));
               issued++;
            end
         end
         if ($urandom_range(0, 3) == 0) begin
            settle();
            case ($urandom_range(0, 4))
               0: lim = 0;
               1: lim = 24'hFFFFFF;
               2: lim = $urandom_range(0, 24'hFFFFFF);
               default: lim = $urandom_range(0, 8000);
            endcase
            write_prune(lim[PRUNE_W-1:0]);
         end
      end

      settle();
      if (mismatches == 0 && pending_answers.size() == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end
endmodule
`default_nettype wire
